>>> design/call_site_target_cache_core_assert.svh
// Assertion macros for the call-site target cache RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CALL_SITE_TARGET_CACHE_CORE_ASSERT_SVH
`define CALL_SITE_TARGET_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("call_site_target_cache_core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CSTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("call_site_target_cache_core: next-cycle check failed");

`endif

>>> design/cstc_pkg.sv
// Shared types and constants of the call-site target cache.
// No dependencies; imported by cstc_ctrl, cstc_datapath and the top level.
package cstc_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int ACT_W   = 2;
  localparam int ENTRY_W = 3 * ADDR_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_INVAL  = 2'd2
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic lookup_go;
    logic update_go;
    logic inval_go;
    logic sweep;
  } cstc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
  } cstc_sts_t;

endpackage

>>> design/cstc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module cstc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/cstc_ctrl.sv
// Controller state machine of the call-site target cache.
// Depends on cstc_pkg and the assertion macro header.
`include "call_site_target_cache_core_assert.svh"

module cstc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cstc_pkg::ACT_W-1:0]      in_action,
  input  cstc_pkg::cstc_sts_t             sts,
  output cstc_pkg::cstc_cmd_t             cmd,
  output logic                            busy,
  output logic                            out_valid
);
  import cstc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SWEEP,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;
  logic   accept;

  assign accept = start && !busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(in_action))
            ACT_LOOKUP: begin
              cmd.lookup_go = 1'b1;
              state_nxt     = S_CMP;
            end
            ACT_UPDATE: cmd.update_go = 1'b1;
            ACT_INVAL: begin
              cmd.inval_go = 1'b1;
              state_nxt    = S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      S_CMP: state_nxt = S_IDLE;
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // The last slot read in the sweep is checked here.
      S_DRAIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_CMP);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  `CSTC_ASSERT_NEXT(a_lookup_result, accept && (in_action == ACT_LOOKUP), out_valid)
  `CSTC_ASSERT_NEXT(a_update_no_stall, accept && (in_action == ACT_UPDATE), !busy && !out_valid)
  `CSTC_ASSERT_NEXT(a_inval_busy, accept && (in_action == ACT_INVAL), busy && !out_valid)
  `CSTC_ASSERT_NOW(a_strobe_busy, out_valid, busy && !cmd.sweep)

endmodule

>>> design/cstc_datapath.sv
// Datapath of the call-site target cache: entry RAM, valid bits, sweep counter, compares.
// Depends on cstc_pkg and cstc_ram.
module cstc_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cstc_pkg::cstc_cmd_t         cmd,
  output cstc_pkg::cstc_sts_t         sts,
  input  logic [cstc_pkg::ADDR_W-1:0] in_call_site,
  input  logic [cstc_pkg::ADDR_W-1:0] in_target,
  input  logic [cstc_pkg::ADDR_W-1:0] in_host_address,
  input  logic [cstc_pkg::ADDR_W-1:0] in_range_start,
  input  logic [cstc_pkg::SIZE_W-1:0] in_range_size,
  output logic                        out_hit,
  output logic [cstc_pkg::ADDR_W-1:0] out_host_result
);
  import cstc_pkg::*;

  logic [ADDR_W-1:0]  site_r;
  logic [ADDR_W-1:0]  tgt_r;
  logic [ADDR_W-1:0]  lo_r;
  logic [ADDR_W:0]    hi_r;
  logic [IDX_W-1:0]   cnt_r;
  logic               chk_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic [ENTRIES-1:0] valid_r;

  logic [IDX_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ADDR_W-1:0]  rd_tag;
  logic [ADDR_W-1:0]  rd_target;
  logic [ADDR_W-1:0]  rd_host;
  logic               in_rng;
  logic               hit;

  // During a sweep the counter owns the port; otherwise the incoming call site does.
  assign ram_addr  = cmd.sweep ? cnt_r : in_call_site[IDX_W-1:0];
  assign ram_wdata = {in_call_site, in_target, in_host_address};

  cstc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.update_go),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign {rd_tag, rd_target, rd_host} = ram_rdata;

  assign in_rng = (rd_target >= lo_r) && ({1'b0, rd_target} < hi_r);
  assign hit    = valid_r[site_r[IDX_W-1:0]] && (rd_tag == site_r) && (rd_target == tgt_r);

  assign out_hit         = hit;
  assign out_host_result = hit ? rd_host : '0;
  assign sts.sweep_last  = (cnt_r == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.lookup_go) begin
      site_r <= in_call_site;
      tgt_r  <= in_target;
    end
    if (cmd.inval_go) begin
      lo_r <= in_range_start;
      hi_r <= {1'b0, in_range_start} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, in_range_size};
    end
    chk_idx_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      chk_r   <= 1'b0;
    end else begin
      chk_r <= cmd.sweep;
      if (cmd.inval_go) begin
        cnt_r <= '0;
      end else if (cmd.sweep) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.update_go) begin
        valid_r[in_call_site[IDX_W-1:0]] <= 1'b1;
      end else if (chk_r && in_rng) begin
        valid_r[chk_idx_r] <= 1'b0;
      end
    end
  end

endmodule

>>> design/call_site_target_cache_core.sv
// Lookup: result strobed on out_valid in the cycle after the beat; busy for that cycle.
// Update: written at the accepting edge, busy stays low, so updates may follow every cycle.
// Invalidate: busy while the single entry-RAM port sweeps every slot, then in the drain state.
// The receiver cannot stall; each result is on the ports for exactly one cycle.
// Synchronous reset clears the valid flip-flops at once; no clearing pass is needed.
// Top level of the call-site target cache; depends on cstc_pkg, cstc_ctrl, cstc_datapath.
module call_site_target_cache_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [cstc_pkg::ACT_W-1:0]  in_action,
  input  logic [cstc_pkg::ADDR_W-1:0] in_call_site,
  input  logic [cstc_pkg::ADDR_W-1:0] in_target,
  input  logic [cstc_pkg::ADDR_W-1:0] in_host_address,
  input  logic [cstc_pkg::ADDR_W-1:0] in_range_start,
  input  logic [cstc_pkg::SIZE_W-1:0] in_range_size,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [cstc_pkg::ADDR_W-1:0] out_host_result
);
  import cstc_pkg::*;

  cstc_cmd_t cmd;
  cstc_sts_t sts;

  cstc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cstc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_call_site    (in_call_site),
    .in_target       (in_target),
    .in_host_address (in_host_address),
    .in_range_start  (in_range_start),
    .in_range_size   (in_range_size),
    .out_hit         (out_hit),
    .out_host_result (out_host_result)
  );

endmodule
